### rtl/core/ete_pkg.sv
package ete_pkg;

    localparam logic [31:0] LOCAL_OFFSET_S = 32'd10800;
    localparam logic [31:0] SEC_PER_DAY    = 32'd86400;
    localparam logic [31:0] MAX_LOCAL_S    = 32'd4102444799;
    localparam logic [11:0] BASE_YEAR      = 12'd1970;
    localparam logic [15:0] DAYS_PER_BLOCK = 16'd1461;

    // days = ((t >> 7) * DAY_RECIP) >> 35, exact for every 32-bit t (86400 = 128 * 675)
    localparam logic [25:0] DAY_RECIP      = 26'd50903317;

    localparam logic [4:0]  BIRTH_DAY_RST   = 5'd1;
    localparam logic [3:0]  BIRTH_MONTH_RST = 4'd1;
    localparam logic [11:0] BIRTH_YEAR_RST  = 12'd1970;

    localparam logic [3:0]  LAST_MONTH = 4'd11;
    localparam logic [3:0]  FEB        = 4'd1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BIRTH_DAY   = 2'd0;
    localparam t_cfg_idx CFG_BIRTH_MONTH = 2'd1;
    localparam t_cfg_idx CFG_BIRTH_YEAR  = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic blk_step;
        logic yr_step;
        logic mo_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic blk_done;
        logic yr_done;
        logic mo_done;
    } t_stat;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:                len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8,
            4'd10:               len = 5'd30;
            default:             len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/ete_in_if.sv
interface ete_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_seconds;

    modport source (output valid, output now_seconds, input ready);
    modport sink   (input valid, input now_seconds, output ready);
endinterface

### rtl/core/ete_out_if.sv
interface ete_out_if;
    logic               valid;
    logic               ready;
    logic        [11:0] cur_year;
    logic        [3:0]  cur_month;
    logic        [4:0]  cur_day;
    logic signed [8:0]  age_years;

    modport source (output valid, output cur_year, output cur_month, output cur_day,
                    output age_years, input ready);
    modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                    input age_years, output ready);
endinterface

### rtl/core/ete_ctrl.sv
module ete_ctrl
    import ete_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_BLOCK  = 6'b000100,
        S_YEAR   = 6'b001000,
        S_MONTH  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_BLOCK;
            end
            S_BLOCK: begin
                if (i_stat.blk_done) n_state = S_YEAR;
                else o_cmd.blk_step = 1'b1;
            end
            S_YEAR: begin
                if (i_stat.yr_done) n_state = S_MONTH;
                else o_cmd.yr_step = 1'b1;
            end
            S_MONTH: begin
                if (i_stat.mo_done) n_state = S_FINISH;
                else o_cmd.mo_step = 1'b1;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/ete_dpath.sv
module ete_dpath
    import ete_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic        [11:0] i_cfg_data,
    input  logic        [31:0] i_now_seconds,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic        [11:0] o_cur_year,
    output logic        [3:0]  o_cur_month,
    output logic        [4:0]  o_cur_day,
    output logic signed [8:0]  o_age_years
);

    logic        [4:0]  r_birth_day;
    logic        [3:0]  r_birth_month;
    logic        [11:0] r_birth_year;

    logic        [24:0] r_local;
    logic        [15:0] r_days;
    logic        [11:0] r_year;
    logic        [3:0]  r_month;

    logic        [11:0] r_out_year;
    logic        [3:0]  r_out_month;
    logic        [4:0]  r_out_day;
    logic signed [8:0]  r_out_age;

    logic        [32:0] w_local;
    logic        [24:0] w_local_sat;
    logic        [50:0] w_days_prod;
    logic               w_leap;
    logic        [8:0]  w_ylen;
    logic        [4:0]  w_mlen;
    logic        [3:0]  w_month1;
    logic        [4:0]  w_day1;
    logic               w_bday_past;
    logic signed [13:0] w_age;
    logic signed [8:0]  w_age_sat;

    assign w_local     = {1'b0, i_now_seconds} + {1'b0, LOCAL_OFFSET_S};
    assign w_local_sat = (w_local > {1'b0, MAX_LOCAL_S}) ? MAX_LOCAL_S[31:7] : w_local[31:7];

    assign w_days_prod = {26'd0, r_local} * {25'd0, DAY_RECIP};

    assign w_leap = (r_year[1:0] == 2'd0);
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_month, w_leap);

    assign o_stat.blk_done = (r_days < DAYS_PER_BLOCK);
    assign o_stat.yr_done  = (r_days < {7'd0, w_ylen});
    assign o_stat.mo_done  = (r_days < {11'd0, w_mlen}) || (r_month == LAST_MONTH);

    assign w_month1    = r_month + 4'd1;
    assign w_day1      = r_days[4:0] + 5'd1;
    assign w_bday_past = (r_birth_month < w_month1) ||
                         ((r_birth_month == w_month1) && (r_birth_day <= w_day1));
    assign w_age       = $signed({2'b00, r_year}) - $signed({2'b00, r_birth_year})
                         - 14'sd1 + (w_bday_past ? 14'sd1 : 14'sd0);
    assign w_age_sat   = (w_age > 14'sd255)  ? 9'sd255 :
                         (w_age < -14'sd256) ? -9'sd256 : w_age[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth_day   <= BIRTH_DAY_RST;
            r_birth_month <= BIRTH_MONTH_RST;
            r_birth_year  <= BIRTH_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIRTH_DAY:   r_birth_day   <= i_cfg_data[4:0];
                CFG_BIRTH_MONTH: r_birth_month <= i_cfg_data[3:0];
                CFG_BIRTH_YEAR:  r_birth_year  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_local <= w_local_sat;
            r_days  <= '0;
            r_year  <= BASE_YEAR;
            r_month <= '0;
        end else if (i_cmd.div_step) begin
            r_days <= w_days_prod[50:35];
        end else if (i_cmd.blk_step) begin
            r_days <= r_days - DAYS_PER_BLOCK;
            r_year <= r_year + 12'd4;
        end else if (i_cmd.yr_step) begin
            r_days <= r_days - {7'd0, w_ylen};
            r_year <= r_year + 12'd1;
        end else if (i_cmd.mo_step) begin
            r_days  <= r_days - {11'd0, w_mlen};
            r_month <= r_month + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_year  <= r_year;
            r_out_month <= w_month1;
            r_out_day   <= w_day1;
            r_out_age   <= w_age_sat;
        end
    end

    assign o_cur_year  = r_out_year;
    assign o_cur_month = r_out_month;
    assign o_cur_day   = r_out_day;
    assign o_age_years = r_out_age;

endmodule

### rtl/core/epoch_seconds_to_age.sv
// Converts a Unix timestamp to the local (UTC+3) calendar date and the completed
// age in years against the birth date held in the configuration registers; times
// past the end of 2099 read as 2099-12-31. One beat is taken at a time: an item
// passes from acceptance to a loaded result through a reciprocal multiply to
// whole days, one step per 4-year block (up to 32), per remaining year (up to
// 3) and per month (up to 11), never more than 45 such steps in all, a closing
// check for each of those three stages, and a final output load that waits
// while an earlier result is still uncollected. The result register frees the
// input side, so the next beat is taken while a result waits to be collected.
module epoch_seconds_to_age
    import ete_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [11:0] i_cfg_data,
    ete_in_if.sink      i_in,
    ete_out_if.source   o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ete_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ete_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_now_seconds (i_in.now_seconds),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_cur_year    (o_out.cur_year),
        .o_cur_month   (o_out.cur_month),
        .o_cur_day     (o_out.cur_day),
        .o_age_years   (o_out.age_years)
    );

endmodule

### rtl/core/ete_checker.sv
module ete_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic       [11:0] i_cur_year,
    input logic       [3:0]  i_cur_month,
    input logic       [4:0]  i_cur_day,
    input logic signed [8:0] i_age_years
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cur_year) &&
        $stable(i_cur_month) && $stable(i_cur_day) && $stable(i_age_years))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second beat taken while busy");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result too early after input beat");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cur_month >= 4'd1 && i_cur_month <= 4'd12 &&
        i_cur_day >= 5'd1 && i_cur_year >= 12'd1970 && i_cur_year <= 12'd2099)
        else $error("date out of range");

endmodule

bind epoch_seconds_to_age ete_checker u_ete_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cur_year  (o_out.cur_year),
    .i_cur_month (o_out.cur_month),
    .i_cur_day   (o_out.cur_day),
    .i_age_years (o_out.age_years)
);
